// File: rtl/tomp_pkg.sv
// Shared types and constants for the time-optimal motion planner.
`default_nettype none
package tomp_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int MAX_SEGMENTS = 6;
	localparam int RESULT_CAP   = 6;
	localparam int SEG_LIMIT    = (MAX_SEGMENTS < RESULT_CAP) ? MAX_SEGMENTS : RESULT_CAP;
	localparam int SEG_W        = $clog2(SEG_LIMIT + 1);
	localparam int ONE_Q        = 1 << FRAC_BITS;
	localparam int POS_TOL      = (ONE_Q + 50000) / 100000;
	localparam int VEL_TOL      = (ONE_Q + 500) / 1000;

	typedef enum logic [2:0] {
		PH_HOLD      = 3'd0,
		PH_REV       = 3'd1,
		PH_ACC_LIM   = 3'd2,
		PH_ACC_PEAK  = 3'd3,
		PH_CRUISE    = 3'd4,
		PH_STOP      = 3'd5,
		PH_BRAKE_LIM = 3'd6
	} ph_t;

	typedef enum logic [1:0] {
		U_MUL,
		U_DIV,
		U_SQRT
	} uop_t;

	typedef enum logic [4:0] {
		C_NONE, C_LOAD, C_PREP, C_EMIT, C_SQVA, C_BVA, C_CLASS,
		C_DUR_VA, C_DUR_WFD, C_VMSQ, C_OFF_LO, C_OFF_HI, C_DUR_VAVM,
		C_DUR_VMVA, C_DNA, C_SQRT, C_PKCMP, C_PKSQ, C_BPK, C_DUR_PK, C_UPDATE
	} cmd_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_EMIT, ST_SQVA, ST_BVA, ST_CLASS, ST_BRANCH,
		ST_DUR_VA, ST_DUR_WFD, ST_VMSQ, ST_OFF_LO, ST_OFF_HI, ST_DUR_VAVM,
		ST_DUR_VMVA, ST_DNA, ST_SQRT, ST_PKCMP, ST_PKSQ, ST_BPK, ST_DUR_PK,
		ST_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		cmd_op_t op;
		logic    go;
		logic    first;
		logic    last;
		logic    err;
	} ctrl_cmd_t;

	typedef struct packed {
		logic unit_done;
		logic plan_done;
		logic out_free;
		logic peak_open;
		logic pk_ge_va;
		ph_t  phase;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/tomp_arith.sv
// Shared iterative multiply, divide and square root unit.
`default_nettype none
module tomp_arith import tomp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire uop_t        op,
	input  wire logic [63:0] x,
	input  wire logic [32:0] y,
	output logic             done,
	output logic [63:0]      res
);

	localparam int MUL_STEPS  = 33;
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;

	logic        busy_q, done_q;
	logic [6:0]  cnt_q;
	uop_t        op_q;
	logic [63:0] acc_q, xa_q, bit_q;
	logic [32:0] yb_q;
	logic [31:0] rem_q;

	logic [32:0] trial;
	logic        ge;
	logic [63:0] rb;
	logic [6:0]  last_cnt;

	always_comb begin
		trial = {rem_q, xa_q[63]};
		ge    = trial >= yb_q;
		rb    = acc_q + bit_q;
		case (op_q)
			U_MUL:   last_cnt = 7'(MUL_STEPS - 1);
			U_DIV:   last_cnt = 7'(DIV_STEPS - 1);
			U_SQRT:  last_cnt = 7'(SQRT_STEPS - 1);
			default: last_cnt = 7'(DIV_STEPS - 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			acc_q <= '0;
			xa_q  <= x;
			yb_q  <= y;
			rem_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			case (op_q)
				U_MUL: begin
					if (yb_q[0]) acc_q <= acc_q + xa_q;
					xa_q <= xa_q << 1;
					yb_q <= yb_q >> 1;
				end
				U_DIV: begin
					rem_q <= ge ? 32'(trial - yb_q) : trial[31:0];
					xa_q  <= {xa_q[62:0], ge};
				end
				U_SQRT: begin
					if (xa_q >= rb) begin
						xa_q  <= xa_q - rb;
						acc_q <= (acc_q >> 1) + bit_q;
					end else begin
						acc_q <= acc_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done = done_q;
	assign res  = (op_q == U_DIV) ? xa_q : acc_q;

endmodule
`default_nettype wire

// File: rtl/tomp_datapath.sv
// Planner datapath: segment state, operand selection, arithmetic unit, output register.
`default_nettype none
module tomp_datapath import tomp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctrl_cmd_t   cmd,
	output dp_stat_t         stat,
	input  wire logic [30:0] max_speed,
	input  wire logic [30:0] max_accel,
	input  wire logic [31:0] start_pos,
	input  wire logic [31:0] start_vel,
	input  wire logic [31:0] target_pos,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       phase,
	output logic [31:0]      effort,
	output logic [31:0]      duration,
	output logic [31:0]      end_pos,
	output logic [31:0]      end_vel,
	output logic [31:0]      total_time,
	output logic             status,
	output logic             last
);

	typedef enum logic [2:0] {D_SQVA, D_BVA, D_T, D_PK, D_DUR, D_OFF, D_OFF_BPK} dst_t;

	logic [30:0] a_u, vm_u;
	logic [31:0] a2;

	logic [31:0] pos_q, vel_q, tgt_q, total_q;
	logic [32:0] dn_q;
	logic [31:0] va_q, pk_q;
	logic        sneg_q, vneg_q, peak_open_q, out_valid_q;
	logic [63:0] sqva_q, bva_q, t_q, dur_q, off_q;
	ph_t         phase_q;
	dst_t        dst_q;

	ph_t         rec_phase_q;
	logic [31:0] rec_eff_q, rec_dur_q, rec_pos_q, rec_vel_q, rec_total_q;
	logic [2:0]  o_phase_q;
	logic [31:0] o_eff_q, o_dur_q, o_pos_q, o_vel_q, o_total_q;
	logic        o_status_q, o_last_q;

	logic        u_start, u_done;
	uop_t        u_op;
	logic [63:0] u_x, u_res;
	logic [32:0] u_y;
	dst_t        u_dst;

	logic [32:0] diff, absdiff;
	logic [31:0] absvel;
	logic        plan_done;
	logic [65:0] wfd;
	logic        wfd_gt;

	logic [64:0] sum, offs;
	logic [31:0] new_pos, vend, new_vel, eff_mag, eff_out, dur_sat;
	logic [32:0] tot_sum;
	logic [31:0] new_total;

	assign a_u  = (max_accel == '0) ? 31'd1 : max_accel;
	assign vm_u = (max_speed == '0) ? 31'd1 : max_speed;
	assign a2   = {a_u, 1'b0};

	always_comb begin
		diff      = {tgt_q[31], tgt_q} - {pos_q[31], pos_q};
		absdiff   = diff[32] ? -diff : diff;
		absvel    = vel_q[31] ? -vel_q : vel_q;
		plan_done = (absdiff <= 33'(POS_TOL)) && (absvel <= 32'(VEL_TOL));
		wfd       = {33'd0, dn_q} - {2'd0, bva_q};
		wfd_gt    = !wfd[65] && (wfd > 66'(POS_TOL));
	end

	// operand selection for the shared unit
	always_comb begin
		u_start = 1'b0;
		u_op    = U_DIV;
		u_x     = '0;
		u_y     = 33'(a_u);
		u_dst   = D_DUR;
		case (cmd.op)
			C_SQVA: begin
				u_start = cmd.go; u_op = U_MUL; u_dst = D_SQVA;
				u_x = 64'(va_q); u_y = {1'b0, va_q};
			end
			C_BVA: begin
				u_start = cmd.go; u_dst = D_BVA; u_x = sqva_q; u_y = 33'(a2);
			end
			C_DUR_VA: begin
				u_start = cmd.go; u_x = 64'(va_q) << FRAC_BITS;
			end
			C_DUR_WFD: begin
				u_start = cmd.go; u_x = wfd[63:0] << FRAC_BITS; u_y = 33'(vm_u);
			end
			C_VMSQ: begin
				u_start = cmd.go; u_op = U_MUL; u_dst = D_T;
				u_x = 64'(vm_u); u_y = 33'(vm_u);
			end
			C_OFF_LO: begin
				u_start = cmd.go; u_dst = D_OFF; u_x = sqva_q - t_q; u_y = 33'(a2);
			end
			C_OFF_HI: begin
				u_start = cmd.go; u_dst = D_OFF; u_x = t_q - sqva_q; u_y = 33'(a2);
			end
			C_DUR_VAVM: begin
				u_start = cmd.go; u_x = 64'(va_q - 32'(vm_u)) << FRAC_BITS;
			end
			C_DUR_VMVA: begin
				u_start = cmd.go; u_x = 64'(32'(vm_u) - va_q) << FRAC_BITS;
			end
			C_DNA: begin
				u_start = cmd.go; u_op = U_MUL; u_dst = D_T;
				u_x = 64'(dn_q); u_y = 33'(a_u);
			end
			C_SQRT: begin
				u_start = cmd.go; u_op = U_SQRT; u_dst = D_PK;
				u_x = t_q + (sqva_q >> 1);
			end
			C_PKSQ: begin
				u_start = cmd.go; u_op = U_MUL; u_dst = D_T;
				u_x = 64'(pk_q); u_y = {1'b0, pk_q};
			end
			C_BPK: begin
				u_start = cmd.go; u_dst = D_OFF_BPK; u_x = t_q; u_y = 33'(a2);
			end
			C_DUR_PK: begin
				u_start = cmd.go; u_x = 64'(pk_q - va_q) << FRAC_BITS;
			end
			default: u_start = 1'b0;
		endcase
	end

	tomp_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.op     (u_op),
		.x      (u_x),
		.y      (u_y),
		.done   (u_done),
		.res    (u_res)
	);

	// segment end state
	always_comb begin
		offs = sneg_q ? -{off_q[63], off_q} : {off_q[63], off_q};
		sum  = {{33{pos_q[31]}}, pos_q} + offs;
		if (!sum[64] && (|sum[63:31]))
			new_pos = 32'h7FFF_FFFF;
		else if (sum[64] && !(&sum[63:31]))
			new_pos = 32'h8000_0000;
		else
			new_pos = sum[31:0];
		case (phase_q)
			PH_REV, PH_STOP: vend = '0;
			PH_ACC_PEAK:     vend = pk_q;
			default:         vend = 32'(vm_u);
		endcase
		new_vel = sneg_q ? -vend : vend;
		case (phase_q)
			PH_REV, PH_ACC_LIM, PH_ACC_PEAK: eff_mag = 32'(a_u);
			PH_STOP, PH_BRAKE_LIM:           eff_mag = -32'(a_u);
			default:                         eff_mag = '0;
		endcase
		eff_out   = sneg_q ? -eff_mag : eff_mag;
		dur_sat   = (|dur_q[63:32]) ? '1 : dur_q[31:0];
		tot_sum   = {1'b0, total_q} + {1'b0, dur_sat};
		new_total = tot_sum[32] ? '1 : tot_sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			peak_open_q <= 1'b0;
		end else begin
			if (cmd.op == C_EMIT && cmd.go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cmd.op == C_CLASS)
				peak_open_q <= !vneg_q && (va_q < 32'(vm_u)) && wfd_gt;
			else if (cmd.op == C_PKCMP)
				peak_open_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (u_start)
			dst_q <= u_dst;
		if (u_done) begin
			case (dst_q)
				D_SQVA:    sqva_q <= u_res;
				D_BVA:     bva_q  <= u_res;
				D_T:       t_q    <= u_res;
				D_PK:      pk_q   <= u_res[31:0];
				D_DUR:     dur_q  <= u_res;
				D_OFF:     off_q  <= u_res;
				D_OFF_BPK: off_q  <= {31'd0, dn_q} - u_res;
				default:   dur_q  <= u_res;
			endcase
		end
		case (cmd.op)
			C_LOAD: if (cmd.go) begin
				pos_q   <= start_pos;
				vel_q   <= start_vel;
				tgt_q   <= target_pos;
				total_q <= '0;
			end
			C_PREP: begin
				dn_q   <= absdiff;
				sneg_q <= diff[32];
				va_q   <= absvel;
				vneg_q <= diff[32] ? (!vel_q[31] && vel_q != '0) : vel_q[31];
				if (cmd.first) begin
					rec_phase_q <= PH_HOLD;
					rec_eff_q   <= '0;
					rec_dur_q   <= '0;
					rec_pos_q   <= pos_q;
					rec_vel_q   <= vel_q;
					rec_total_q <= '0;
				end
			end
			C_CLASS: begin
				if (vneg_q) begin
					phase_q <= PH_REV;
					off_q   <= -bva_q;
				end else if (va_q < 32'(vm_u) && wfd_gt) begin
					phase_q <= PH_ACC_PEAK;
				end else if (va_q == 32'(vm_u) && wfd_gt) begin
					phase_q <= PH_CRUISE;
					off_q   <= wfd[63:0];
				end else if (va_q <= 32'(vm_u)) begin
					phase_q <= PH_STOP;
					off_q   <= bva_q;
				end else begin
					phase_q <= PH_BRAKE_LIM;
				end
			end
			C_PKCMP: begin
				phase_q <= (32'(vm_u) < pk_q) ? PH_ACC_LIM : PH_ACC_PEAK;
				dur_q   <= '0;
			end
			C_UPDATE: begin
				pos_q       <= new_pos;
				vel_q       <= new_vel;
				total_q     <= new_total;
				rec_phase_q <= phase_q;
				rec_eff_q   <= eff_out;
				rec_dur_q   <= dur_sat;
				rec_pos_q   <= new_pos;
				rec_vel_q   <= new_vel;
				rec_total_q <= new_total;
			end
			C_EMIT: if (cmd.go) begin
				o_phase_q  <= rec_phase_q;
				o_eff_q    <= rec_eff_q;
				o_dur_q    <= rec_dur_q;
				o_pos_q    <= rec_pos_q;
				o_vel_q    <= rec_vel_q;
				o_total_q  <= rec_total_q;
				o_status_q <= cmd.err;
				o_last_q   <= cmd.last;
			end
			default: pos_q <= pos_q;
		endcase
	end

	always_comb begin
		stat.unit_done = u_done;
		stat.plan_done = plan_done;
		stat.out_free  = !out_valid_q || !out_stall;
		stat.peak_open = peak_open_q;
		stat.pk_ge_va  = pk_q >= va_q;
		stat.phase     = phase_q;
	end

	assign out_valid  = out_valid_q;
	assign phase      = o_phase_q;
	assign effort     = o_eff_q;
	assign duration   = o_dur_q;
	assign end_pos    = o_pos_q;
	assign end_vel    = o_vel_q;
	assign total_time = o_total_q;
	assign status     = o_status_q;
	assign last       = o_last_q;

endmodule
`default_nettype wire

// File: rtl/tomp_ctrl.sv
// Planner sequencer: steps each segment through the shared arithmetic unit.
`default_nettype none
module tomp_ctrl import tomp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output ctrl_cmd_t     cmd
);

	ctrl_state_t       state_q, state_d;
	logic              issued_q, unit_state;
	logic [SEG_W-1:0]  n_q;
	logic              at_limit;

	assign at_limit = n_q == SEG_W'(SEG_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			n_q      <= '0;
		end else begin
			state_q <= state_d;
			if (stat.unit_done)
				issued_q <= 1'b0;
			else if (unit_state)
				issued_q <= 1'b1;
			if (state_q == ST_IDLE && in_valid)
				n_q <= '0;
			else if (state_q == ST_UPDATE)
				n_q <= n_q + SEG_W'(1);
		end
	end

	always_comb begin
		state_d    = state_q;
		unit_state = 1'b0;
		in_stall   = 1'b1;
		cmd.op     = C_NONE;
		cmd.go     = 1'b1;
		cmd.first  = n_q == '0;
		cmd.last   = stat.plan_done || at_limit;
		cmd.err    = !stat.plan_done && at_limit;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.op   = C_LOAD;
				cmd.go   = in_valid;
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.op  = C_PREP;
				state_d = (stat.plan_done || n_q != '0) ? ST_EMIT : ST_SQVA;
			end
			ST_EMIT: begin
				cmd.op = C_EMIT;
				cmd.go = stat.out_free;
				if (stat.out_free)
					state_d = cmd.last ? ST_IDLE : ST_SQVA;
			end
			ST_CLASS: begin
				cmd.op  = C_CLASS;
				state_d = ST_BRANCH;
			end
			ST_BRANCH: begin
				if (stat.peak_open)
					state_d = ST_DNA;
				else begin
					case (stat.phase)
						PH_CRUISE:               state_d = ST_DUR_WFD;
						PH_ACC_LIM, PH_BRAKE_LIM: state_d = ST_VMSQ;
						PH_ACC_PEAK:             state_d = ST_PKSQ;
						default:                 state_d = ST_DUR_VA;
					endcase
				end
			end
			ST_PKCMP: begin
				cmd.op  = C_PKCMP;
				state_d = ST_BRANCH;
			end
			ST_UPDATE: begin
				cmd.op  = C_UPDATE;
				state_d = ST_PREP;
			end
			default: begin
				// states that run one operation on the arithmetic unit
				unit_state = !issued_q;
				cmd.go     = !issued_q;
				case (state_q)
					ST_SQVA:     cmd.op = C_SQVA;
					ST_BVA:      cmd.op = C_BVA;
					ST_DUR_VA:   cmd.op = C_DUR_VA;
					ST_DUR_WFD:  cmd.op = C_DUR_WFD;
					ST_VMSQ:     cmd.op = C_VMSQ;
					ST_OFF_LO:   cmd.op = C_OFF_LO;
					ST_OFF_HI:   cmd.op = C_OFF_HI;
					ST_DUR_VAVM: cmd.op = C_DUR_VAVM;
					ST_DUR_VMVA: cmd.op = C_DUR_VMVA;
					ST_DNA:      cmd.op = C_DNA;
					ST_SQRT:     cmd.op = C_SQRT;
					ST_PKSQ:     cmd.op = C_PKSQ;
					ST_BPK:      cmd.op = C_BPK;
					ST_DUR_PK:   cmd.op = C_DUR_PK;
					default:     cmd.op = C_NONE;
				endcase
				if (stat.unit_done) begin
					case (state_q)
						ST_SQVA:  state_d = ST_BVA;
						ST_BVA:   state_d = ST_CLASS;
						ST_VMSQ:
							state_d = (stat.phase == PH_BRAKE_LIM) ? ST_OFF_LO : ST_OFF_HI;
						ST_OFF_LO: state_d = ST_DUR_VAVM;
						ST_OFF_HI: state_d = ST_DUR_VMVA;
						ST_DNA:    state_d = ST_SQRT;
						ST_SQRT:   state_d = ST_PKCMP;
						ST_PKSQ:   state_d = ST_BPK;
						ST_BPK:    state_d = stat.pk_ge_va ? ST_DUR_PK : ST_UPDATE;
						default:   state_d = ST_UPDATE;
					endcase
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/time_optimal_motion_planner_core.sv
// Time-optimal motion planner: top level with limit registers and APB port.
//
// Input channel: start_pos, start_vel, target_pos with in_valid/in_stall.
// An item is taken when in_valid is high and in_stall is low; in_stall is
// low only while no plan is in progress.
// Output channel: one item per segment (phase, effort, duration, end_pos,
// end_vel, total_time, status, last) with out_valid/out_stall; last marks
// the final segment, status flags a plan cut off at the segment limit.
// Timing: every segment runs through one shared iterative unit (33-step
// multiply, 64-step divide, 32-step root). The peak-speed segment is the
// longest, and the 64-step divides set most of it. A start already at the
// target passes through the PREP and EMIT states before out_valid rises
// for its hold item. A plan holds the input off until its last item is
// loaded into the output register.
// A stalled output item holds in its register; the planner waits there
// before loading another one.
// Reset clears the sequencer and output valid; max_speed and max_accel
// return to 1.0 (65536). Write the limits over APB only while idle.
`default_nettype none
module time_optimal_motion_planner_core import tomp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] start_pos,
	input  wire logic [31:0] start_vel,
	input  wire logic [31:0] target_pos,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       phase,
	output logic [31:0]      effort,
	output logic [31:0]      duration,
	output logic [31:0]      end_pos,
	output logic [31:0]      end_vel,
	output logic [31:0]      total_time,
	output logic             status,
	output logic             last
);

	localparam logic REG_MAX_SPEED = 1'b0;
	localparam logic REG_MAX_ACCEL = 1'b1;

	logic [30:0] max_speed_q, max_accel_q;
	logic        wr;
	ctrl_cmd_t   cmd;
	dp_stat_t    stat;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 31'd65536;
			max_accel_q <= 31'd65536;
		end else if (wr) begin
			if (paddr[2] == REG_MAX_SPEED) max_speed_q <= pwdata[30:0];
			if (paddr[2] == REG_MAX_ACCEL) max_accel_q <= pwdata[30:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_ACCEL) ? {1'b0, max_accel_q} : {1'b0, max_speed_q};

	tomp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tomp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.max_speed  (max_speed_q),
		.max_accel  (max_accel_q),
		.start_pos  (start_pos),
		.start_vel  (start_vel),
		.target_pos (target_pos),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.phase      (phase),
		.effort     (effort),
		.duration   (duration),
		.end_pos    (end_pos),
		.end_vel    (end_vel),
		.total_time (total_time),
		.status     (status),
		.last       (last)
	);

endmodule
`default_nettype wire

// File: verif/time_optimal_motion_planner_checker.sv
// Checker for the motion planner: predicts segment items and compares outputs.
`default_nettype none
module time_optimal_motion_planner_checker import tomp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] start_pos,
	input  wire logic [31:0] start_vel,
	input  wire logic [31:0] target_pos,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  phase,
	input  wire logic [31:0] effort,
	input  wire logic [31:0] duration,
	input  wire logic [31:0] end_pos,
	input  wire logic [31:0] end_vel,
	input  wire logic [31:0] total_time,
	input  wire logic        status,
	input  wire logic        last,
	output int               errors,
	output int               pending,
	output int               seg_count,
	output int               plan_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_SPEED = 3'd0;
	localparam logic [2:0] ADDR_ACCEL = 3'd4;
	localparam longint MASK32 = 64'hFFFF_FFFF;

	typedef struct packed {
		ph_t         ph;
		logic [31:0] eff;
		logic [31:0] dur;
		logic [31:0] epos;
		logic [31:0] evel;
		logic [31:0] tot;
		logic        stat;
		logic        lst;
	} segment_t;

	segment_t segq[$];
	logic [63:0] speed_lim, accel_lim;

	function automatic longint sat_s(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic [63:0] sat_u(logic [63:0] x);
		return (x > MASK32) ? MASK32 : x;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit at_rest(longint d, longint v);
		longint ad, av;
		ad = d < 0 ? -d : d;
		av = v < 0 ? -v : v;
		return ad <= POS_TOL && av <= VEL_TOL;
	endfunction

	task automatic plan_segments(logic [31:0] sp, logic [31:0] sv, logic [31:0] tp);
		longint pos, vel, tgt, diff, s, v, vmax, wfd, eff, off, vend;
		logic [63:0] a, dn, va, pk, vm, dur, total, stopd;
		ph_t ph;
		int n;
		segment_t r;
		pos = longint'($signed(sp));
		vel = longint'($signed(sv));
		tgt = longint'($signed(tp));
		diff = tgt - pos;
		total = 0;
		n = 0;
		a = accel_lim == 0 ? 1 : accel_lim;
		vmax = speed_lim == 0 ? 1 : longint'(speed_lim);
		if (at_rest(diff, vel)) begin
			r = '{PH_HOLD, 32'd0, 32'd0, sp, sv, 32'd0, 1'b0, 1'b1};
			segq.insert(segq.size(), r);
			return;
		end
		while (n < SEG_LIMIT) begin
			s = diff < 0 ? -1 : 1;
			dn = diff < 0 ? -diff : diff;
			v = vel * s;
			va = v < 0 ? -v : v;
			stopd = (va * va) / (2 * a);
			wfd = longint'(dn) - longint'(stopd);
			if (v < 0) begin
				ph = PH_REV; eff = a; dur = sat_u((va << FRAC_BITS) / a);
				off = -longint'(stopd); vend = 0;
			end else if (v < vmax && wfd > POS_TOL) begin
				pk = root_floor(dn * a + (va * va) / 2);
				eff = a;
				if (vmax < pk) begin
					vm = vmax;
					ph = PH_ACC_LIM; dur = sat_u(((vm - va) << FRAC_BITS) / a);
					off = longint'((vm * vm - va * va) / (2 * a)); vend = vmax;
				end else begin
					ph = PH_ACC_PEAK;
					dur = pk >= va ? sat_u(((pk - va) << FRAC_BITS) / a) : 0;
					off = longint'(dn) - longint'((pk * pk) / (2 * a));
					vend = longint'(pk);
				end
			end else if (v == vmax && wfd > POS_TOL) begin
				ph = PH_CRUISE; eff = 0;
				dur = sat_u(($unsigned(wfd) << FRAC_BITS) / vmax);
				off = wfd; vend = vmax;
			end else if (v <= vmax) begin
				ph = PH_STOP; eff = -longint'(a); dur = sat_u((va << FRAC_BITS) / a);
				off = longint'(stopd); vend = 0;
			end else begin
				vm = vmax;
				ph = PH_BRAKE_LIM; eff = -longint'(a);
				dur = sat_u(((va - vm) << FRAC_BITS) / a);
				off = longint'((va * va - vm * vm) / (2 * a)); vend = vmax;
			end
			pos = sat_s(pos + s * off);
			vel = s * vend;
			total = sat_u(total + dur);
			diff = tgt - pos;
			n++;
			r.ph = ph;
			r.eff = 32'(s * eff);
			r.dur = dur[31:0];
			r.epos = 32'(pos);
			r.evel = 32'(vel);
			r.tot = total[31:0];
			r.lst = at_rest(diff, vel) || n == SEG_LIMIT;
			r.stat = !at_rest(diff, vel) && n == SEG_LIMIT;
			segq.insert(segq.size(), r);
			if (r.lst) return;
		end
	endtask

	task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
		$display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		segment_t e;
		if (!arst_n) begin
			speed_lim <= 65536;
			accel_lim <= 65536;
			errors = 0;
			seg_count = 0;
			plan_count = 0;
			segq.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == ADDR_SPEED) speed_lim <= pwdata & 32'h7FFF_FFFF;
				if (paddr == ADDR_ACCEL) accel_lim <= pwdata & 32'h7FFF_FFFF;
			end
			if (out_valid && !out_stall) begin
				seg_count++;
				if (segq.size() == 0) begin
					$display("%0t: unexpected segment item, phase %0d", $time, phase);
					errors++;
				end else begin
					e = segq.pop_front();
					if (phase != e.ph) report("phase", e.ph, phase);
					if (effort != e.eff) report("effort", e.eff, effort);
					if (duration != e.dur) report("duration", e.dur, duration);
					if (end_pos != e.epos) report("end_pos", e.epos, end_pos);
					if (end_vel != e.evel) report("end_vel", e.evel, end_vel);
					if (total_time != e.tot) report("total_time", e.tot, total_time);
					if (status != e.stat) report("status", e.stat, status);
					if (last != e.lst) report("last", e.lst, last);
				end
			end
			// queue after the compare so a same-edge accept never feeds itself
			if (in_valid && !in_stall) begin
				plan_count++;
				plan_segments(start_pos, start_vel, target_pos);
			end
			pending = segq.size();
		end
	end
endmodule
`default_nettype wire

// File: verif/time_optimal_motion_planner_core_tb.sv
// Testbench top: drives plans and limit writes into the motion planner core.
`default_nettype none
module time_optimal_motion_planner_core_tb import tomp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_SPEED = 3'd0;
	localparam logic [2:0] ADDR_ACCEL = 3'd4;
	localparam int STALL_LIMIT = 200000;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall, out_valid, out_stall = 1;
	logic [31:0] start_pos = '0, start_vel = '0, target_pos = '0;
	logic [2:0] phase;
	logic [31:0] effort, duration, end_pos, end_vel, total_time;
	logic status, last;
	int errors, pending, seg_count, plan_count;
	int idle_cycles = 0;
	bit calm = 0, hold_off = 0, rx_on = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	time_optimal_motion_planner_core dut (.*);
	time_optimal_motion_planner_checker chk (.*);

	always @(negedge clk) begin
		if (!rx_on || hold_off) out_stall <= 1;
		else out_stall <= calm ? 0 : ($urandom_range(99) < 15);
	end

	initial begin : receiver_hold
		wait (plan_count >= 30);
		hold_off = 1;
		repeat (3000) @(negedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// in_valid stays up after an accept; the next call or drain() settles it
	task automatic send_plan(logic [31:0] sp, logic [31:0] sv, logic [31:0] tp);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid <= 0;
			@(negedge clk);
		end
		start_pos <= sp; start_vel <= sv; target_pos <= tp; in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	// mostly moderate moves, a few at the full range
	function automatic logic [31:0] pick_val(int scale);
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'($signed($urandom_range(200)) - 100);
			default: return 32'($signed($urandom_range(2 * scale)) - scale);
		endcase
	endfunction

	initial begin
		logic [31:0] sp;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		rx_on = 1;
		// directed
		send_plan(32'd100, 32'd0, 32'd100);
		send_plan(32'd0, 32'd0, 32'h0001_0000 * 4);
		send_plan(32'd0, 32'd0, 32'h0000_8000);
		send_plan(32'd0, 32'hFFFE_0000, 32'h0002_0000);
		send_plan(32'd0, 32'h0003_0000, 32'h0001_0000);
		send_plan(32'd0, 32'h0001_0000, 32'h0010_0000);
		send_plan(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_plan(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_plan(32'h7FFF_0000, 32'h0100_0000, 32'h7FFF_FFFF);
		send_plan(32'd0, 32'h8000_0000, 32'd0);
		send_plan(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
		reg_write(ADDR_SPEED, 32'd0);
		reg_write(ADDR_ACCEL, 32'd0);
		send_plan(32'd0, 32'd0, 32'd300);
		send_plan(32'd0, 32'd5, 32'hFFFF_FF00);
		drain();
		reg_write(ADDR_SPEED, 32'hFFFF_FFFF);
		reg_write(ADDR_ACCEL, 32'h7FFF_FFFF);
		send_plan(32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
		send_plan(32'd0, 32'h7FFF_FFFF, 32'hFFFF_0000);
		drain();
		// random phases over several limit settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin reg_write(ADDR_SPEED, 32'h0001_0000); reg_write(ADDR_ACCEL, 32'h0001_0000); end
				1: begin reg_write(ADDR_SPEED, 32'h0008_0000); reg_write(ADDR_ACCEL, 32'h0000_4000); end
				2: begin reg_write(ADDR_SPEED, $urandom_range(32'h7FFF_FFFF, 1));
					reg_write(ADDR_ACCEL, $urandom_range(32'h7FFF_FFFF, 1)); end
				3: begin reg_write(ADDR_SPEED, 32'h0000_0100); reg_write(ADDR_ACCEL, 32'h0100_0000); end
				default: begin reg_write(ADDR_SPEED, 32'h0004_0000); reg_write(ADDR_ACCEL, 32'h0002_0000); end
			endcase
			calm = (ph == 1);
			for (int k = 0; k < 52; k++) begin
				sp = pick_val(32'h0040_0000);
				if ($urandom_range(15) == 0) send_plan(sp, pick_val(200), sp + pick_val(20));
				else send_plan(sp, pick_val(32'h0008_0000), sp + pick_val(32'h0040_0000));
			end
			calm = 0;
			drain();
		end
		$display("Covered %0d plans and %0d segment items over seven limit settings.",
			plan_count, seg_count);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
